// File: rtl/kstc_pkg.sv
// ============================================================================
// kstc_pkg: shared types and constants for the keypad scan trigger controller
// Holds the field widths, bus packing, register defaults and mode codes
// that the top level, the key decoder and the checker all rely on.
// ============================================================================
`default_nettype none

package kstc_pkg;

    // Matrix geometry defaults.
    localparam int DEF_MATRIX_ROWS = 5;
    localparam int DEF_MATRIX_COLS = 4;

    // Field widths.
    localparam int DIRECT_W  = 4;
    localparam int MATRIX_W  = 20;
    localparam int TIME_W    = 32;
    localparam int KEY_W     = 24;
    localparam int MODE_W    = 2;
    localparam int COUNT_W   = 9;
    localparam int TIMEOUT_W = 16;

    // Stream widths, padded to whole bytes.
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 32;

    // Input tdata layout.
    localparam int IN_DIRECT_LSB = 0;
    localparam int IN_MATRIX_LSB = IN_DIRECT_LSB + DIRECT_W;
    localparam int IN_ENABLE_BIT = IN_MATRIX_LSB + MATRIX_W;
    localparam int IN_TIME_LSB   = IN_ENABLE_BIT + 1;

    // Output tdata layout.
    localparam int OUT_KEY_LSB  = 0;
    localparam int OUT_TRIG_BIT = OUT_KEY_LSB + KEY_W;
    localparam int OUT_LED_BIT  = OUT_TRIG_BIT + 1;
    localparam int OUT_MODE_LSB = OUT_LED_BIT + 1;
    localparam int OUT_USED_W   = OUT_MODE_LSB + MODE_W;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIRECT_LEVELS = 3'd0,
        CFG_MATRIX_LEVEL  = 3'd1,
        CFG_AUTO_TIMEOUT  = 3'd2,
        CFG_PULSE_PERIOD  = 3'd3,
        CFG_PULSE_ON_THR  = 3'd4
    } t_cfg_idx;

    // Register defaults.
    localparam logic [DIRECT_W-1:0]  RST_DIRECT_LEVELS = 4'd1;
    localparam logic                 RST_MATRIX_LEVEL  = 1'b0;
    localparam logic [TIMEOUT_W-1:0] RST_AUTO_TIMEOUT  = 16'd12000;
    localparam logic [COUNT_W-1:0]   RST_PULSE_PERIOD  = 9'd400;
    localparam logic [COUNT_W-1:0]   RST_PULSE_ON_THR  = 9'd150;

    // Item kinds carried in tuser.
    typedef enum logic {
        KIND_POLL  = 1'b0,
        KIND_CLEAR = 1'b1
    } t_kind;

    // Trigger mode codes as they appear on the output.
    typedef enum logic [MODE_W-1:0] {
        MODE_MANUAL  = 2'd0,
        MODE_AUTO    = 2'd1,
        MODE_ARMING  = 2'd2,
        MODE_CLOSING = 2'd3
    } t_mode;

    // Key word bits for the trigger keys.
    localparam logic [KEY_W-1:0] SCAN_KEY_MASK = 24'h00000E;
    localparam int               F1_BIT        = 3;

endpackage

`default_nettype wire

// File: rtl/kstc_key_decode.sv
// ============================================================================
// kstc_key_decode: pin levels to pressed-key word
// Compares each direct pin and each matrix column level with its active
// level and builds the key word: direct keys low, matrix keys row by row.
// ============================================================================
`default_nettype none

module kstc_key_decode
    import kstc_pkg::*;
#(
    parameter int MATRIX_ROWS = DEF_MATRIX_ROWS,
    parameter int MATRIX_COLS = DEF_MATRIX_COLS
) (
    input  wire logic [DIRECT_W-1:0] i_direct_pins,
    input  wire logic [MATRIX_W-1:0] i_matrix_pins,
    input  wire logic [DIRECT_W-1:0] i_direct_levels,
    input  wire logic                i_matrix_level,
    output logic      [KEY_W-1:0]    o_keys
);

    localparam int NUM_KEYS = MATRIX_ROWS * MATRIX_COLS;

    // A direct key is pressed when its pin matches the active level.
    assign o_keys[DIRECT_W-1:0] = ~(i_direct_pins ^ i_direct_levels);

    // Matrix keys beyond the scanned matrix read as not pressed.
    for (genvar g = 0; g < MATRIX_W; g++) begin : g_matrix
        if (g < NUM_KEYS && g + DIRECT_W < KEY_W) begin : g_used
            assign o_keys[g + DIRECT_W] = (i_matrix_pins[g] == i_matrix_level);
        end else begin : g_unused
            assign o_keys[g + DIRECT_W] = 1'b0;
        end
    end

endmodule

`default_nettype wire

// File: rtl/keypad_scan_trigger_controller_top.sv
// Path: a poll transfer is captured in the input register and its result in the result register,
// which presents it on the result stream. Throughput: one item per cycle unless the output stalls;
// each poll is decoded and the trigger state updated in one pass.
// Backpressure on the output stalls the result register first, then the input register.
// Reset (i_rst_n low at a clock edge) clears both valid flags, returns the trigger machine
// to manual with trigger and LED off, and restores the configuration registers to defaults.
// ============================================================================
// keypad_scan_trigger_controller_top: keypad scan and barcode trigger control
// Decodes key pins into a key word and runs the manual / arming / auto /
// closing trigger machine that pulses the scanner trigger in auto mode.
// ============================================================================
`default_nettype none

module keypad_scan_trigger_controller_top
    import kstc_pkg::*;
#(
    parameter int MATRIX_ROWS = DEF_MATRIX_ROWS,
    parameter int MATRIX_COLS = DEF_MATRIX_COLS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Poll stream.
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // Bits up from 0: direct_pins[4], matrix_pins[20], scan_enable[1], now_time[32], zero pad.
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // Bit 0: kind.
    input  wire logic                  s_axis_tuser,
    // Result stream.
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // Bits up from 0: key_status[24], trigger_on[1], led_red[1], auto_mode[2], zero pad.
    output logic      [OUT_DATA_W-1:0] m_axis_tdata,
    // Configuration writes.
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    // Configuration registers.
    logic [DIRECT_W-1:0]  r_direct_levels;
    logic                 r_matrix_level;
    logic [TIMEOUT_W-1:0] r_auto_timeout;
    logic [COUNT_W-1:0]   r_pulse_period;
    logic [COUNT_W-1:0]   r_pulse_on_thr;

    // Pipeline registers.
    logic                  r_in_vld;
    logic [IN_DATA_W-1:0]  r_in_data;
    logic                  r_in_kind;
    logic                  r_out_vld;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                  w_adv;

    // Trigger machine state and its next values.
    t_mode              r_mode,       n_mode;
    logic               r_shadow,     n_shadow;
    logic               r_trig,       n_trig;
    logic               r_led,        n_led;
    logic [COUNT_W-1:0] r_count,      n_count;
    logic [TIME_W-1:0]  r_start_time, n_start_time;
    logic [KEY_W-1:0]   n_status;

    // Fields of the registered input item.
    logic [DIRECT_W-1:0] w_direct;
    logic [MATRIX_W-1:0] w_matrix;
    logic                w_enable;
    logic [TIME_W-1:0]   w_now;
    logic [KEY_W-1:0]    w_keys;
    logic                w_scan_key;
    logic                w_f1;
    logic [COUNT_W-1:0]  w_count_dec;
    logic [TIME_W-1:0]   w_elapsed;
    logic                w_timeout;

    assign w_direct = r_in_data[IN_DIRECT_LSB +: DIRECT_W];
    assign w_matrix = r_in_data[IN_MATRIX_LSB +: MATRIX_W];
    assign w_enable = r_in_data[IN_ENABLE_BIT];
    assign w_now    = r_in_data[IN_TIME_LSB +: TIME_W];

    // Handshake: the input register moves on whenever the result register can take it.
    assign w_adv         = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || w_adv;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direct_levels <= RST_DIRECT_LEVELS;
            r_matrix_level  <= RST_MATRIX_LEVEL;
            r_auto_timeout  <= RST_AUTO_TIMEOUT;
            r_pulse_period  <= RST_PULSE_PERIOD;
            r_pulse_on_thr  <= RST_PULSE_ON_THR;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_DIRECT_LEVELS: r_direct_levels <= i_cfg_wdata[DIRECT_W-1:0];
                CFG_MATRIX_LEVEL:  r_matrix_level  <= i_cfg_wdata[0];
                CFG_AUTO_TIMEOUT:  r_auto_timeout  <= i_cfg_wdata[TIMEOUT_W-1:0];
                CFG_PULSE_PERIOD:  r_pulse_period  <= i_cfg_wdata[COUNT_W-1:0];
                CFG_PULSE_ON_THR:  r_pulse_on_thr  <= i_cfg_wdata[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_data <= s_axis_tdata;
            r_in_kind <= s_axis_tuser;
        end
    end

    // Key decode of the registered poll.
    kstc_key_decode #(
        .MATRIX_ROWS (MATRIX_ROWS),
        .MATRIX_COLS (MATRIX_COLS)
    ) u_key_decode (
        .i_direct_pins   (w_direct),
        .i_matrix_pins   (w_matrix),
        .i_direct_levels (r_direct_levels),
        .i_matrix_level  (r_matrix_level),
        .o_keys          (w_keys)
    );

    assign w_scan_key  = |(w_keys & SCAN_KEY_MASK);
    assign w_f1        = w_keys[F1_BIT];
    assign w_count_dec = r_count - COUNT_W'(1);
    assign w_elapsed   = w_now - r_start_time;
    assign w_timeout   = w_elapsed >= {{(TIME_W-TIMEOUT_W){1'b0}}, r_auto_timeout};

    // Trigger machine: next state and result word.
    always_comb begin
        n_mode       = r_mode;
        n_shadow     = r_shadow;
        n_trig       = r_trig;
        n_led        = r_led;
        n_count      = r_count;
        n_start_time = r_start_time;
        n_status     = '0;

        if (r_in_kind == KIND_CLEAR) begin
            // A clear event restarts the pulse timing in auto mode.
            if (r_mode == MODE_AUTO) begin
                n_trig       = 1'b0;
                n_count      = r_pulse_on_thr;
                n_start_time = w_now;
            end
        end else if (!w_enable) begin
            // Scanning off: auto mode falls back to manual, keys pass unmasked.
            n_status = w_keys;
            if (r_mode == MODE_AUTO) begin
                n_mode   = MODE_MANUAL;
                n_trig   = 1'b0;
                n_shadow = 1'b0;
                n_count  = '0;
                n_led    = 1'b0;
            end
        end else begin
            n_status = w_keys & ~SCAN_KEY_MASK;
            case (r_mode)
                MODE_MANUAL: begin
                    // Trigger follows the scan keys; F1 arms auto mode.
                    if (!r_shadow && w_scan_key) begin
                        n_trig   = 1'b1;
                        n_shadow = 1'b1;
                    end else if (r_shadow && !w_scan_key) begin
                        n_trig   = 1'b0;
                        n_shadow = 1'b0;
                    end
                    if (w_f1) begin
                        n_shadow = 1'b0;
                        n_mode   = MODE_ARMING;
                        n_count  = '0;
                        n_led    = 1'b1;
                        n_trig   = 1'b1;
                    end
                end
                MODE_ARMING: begin
                    if (!w_scan_key) begin
                        n_mode       = MODE_AUTO;
                        n_start_time = w_now;
                    end
                end
                MODE_CLOSING: begin
                    if (!w_scan_key) begin
                        n_mode = MODE_MANUAL;
                    end
                end
                MODE_AUTO: begin
                    // Pulse down-counter with trigger toggling at the threshold.
                    if (r_count == '0) begin
                        n_count  = r_pulse_period;
                        n_shadow = 1'b0;
                    end else begin
                        n_count = w_count_dec;
                        if (!r_shadow && w_count_dec >= r_pulse_on_thr) begin
                            n_trig   = 1'b1;
                            n_shadow = 1'b1;
                        end else if (r_shadow && w_count_dec < r_pulse_on_thr) begin
                            n_trig   = 1'b0;
                            n_shadow = 1'b0;
                        end
                    end
                    // Timeout or F1 closes auto mode.
                    if (w_timeout || w_f1) begin
                        n_mode   = MODE_CLOSING;
                        n_trig   = 1'b0;
                        n_shadow = 1'b0;
                        n_count  = '0;
                        n_led    = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Trigger machine state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_MANUAL;
            r_shadow     <= 1'b0;
            r_trig       <= 1'b0;
            r_led        <= 1'b0;
            r_count      <= '0;
            r_start_time <= '0;
        end else if (w_adv) begin
            r_mode       <= n_mode;
            r_shadow     <= n_shadow;
            r_trig       <= n_trig;
            r_led        <= n_led;
            r_count      <= n_count;
            r_start_time <= n_start_time;
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (!r_out_vld || m_axis_tready) begin
            r_out_vld <= r_in_vld;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_data <= {{(OUT_DATA_W-OUT_USED_W){1'b0}}, n_mode, n_led, n_trig, n_status};
        end
    end

endmodule

`default_nettype wire

// File: rtl/kstc_checker.sv
// ============================================================================
// kstc_checker: port-level checks for the keypad scan trigger controller
// Watches the result stream and checks that the reported trigger and LED
// levels agree with the reported mode.
// ============================================================================
`default_nettype none

module kstc_checker
    import kstc_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic [MODE_W-1:0] w_mode;
    logic              w_trig;
    logic              w_led;

    assign w_mode = m_axis_tdata[OUT_MODE_LSB +: MODE_W];
    assign w_trig = m_axis_tdata[OUT_TRIG_BIT];
    assign w_led  = m_axis_tdata[OUT_LED_BIT];

    // A stalled result keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // The red LED is lit exactly while arming or auto scanning.
    a_led_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_led == (w_mode == MODE_AUTO || w_mode == MODE_ARMING)))
        else $error("LED level disagrees with trigger mode");

    // Arming holds the trigger on until the scan keys are released.
    a_arming_trig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_mode == MODE_ARMING |-> w_trig)
        else $error("trigger off while arming");

    // Closing keeps the trigger off.
    a_closing_trig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_mode == MODE_CLOSING |-> !w_trig)
        else $error("trigger on while closing");

endmodule

bind keypad_scan_trigger_controller_top kstc_checker u_kstc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// File: sim/kstc_trigger_monitor.sv
// ============================================================================
// kstc_trigger_monitor: result checker for the keypad scan trigger controller
// Watches the poll, result and configuration ports, keeps its own copy of the
// key decoder and trigger mode machine, and compares every result transfer
// field by field with the oldest predicted status.
// ============================================================================
`timescale 1ns / 100ps

module kstc_trigger_monitor
    import kstc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    input  wire logic                  s_axis_tready,
    // Bits up from 0: direct_pins[4], matrix_pins[20], scan_enable[1], now_time[32], zero pad.
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // Bit 0: kind.
    input  wire logic                  s_axis_tuser,
    input  wire logic                  m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // Bits up from 0: key_status[24], trigger_on[1], led_red[1], auto_mode[2], zero pad.
    input  wire logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output int                         o_fail_count,
    output int                         o_pending
);

    // One result item as it leaves the block.
    typedef struct packed {
        t_mode            mode;
        logic             led;
        logic             trig;
        logic [KEY_W-1:0] keys;
    } t_status;

    // Configuration copy.
    logic [DIRECT_W-1:0]  lvl_direct;
    logic                 lvl_matrix;
    logic [TIMEOUT_W-1:0] auto_timeout;
    logic [COUNT_W-1:0]   pulse_reload;
    logic [COUNT_W-1:0]   pulse_thr;

    // Trigger machine copy.
    t_mode                trig_mode;
    logic                 shadow;
    logic                 trig_level;
    logic                 led_level;
    logic [COUNT_W-1:0]   pulse_count;
    logic [TIME_W-1:0]    auto_start;

    t_status status_due[$];
    t_status want;
    t_status got;
    t_status next_status;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Print one line per mismatch and count it.
    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        o_fail_count++;
    endtask

    // Leave auto mode with trigger and LED off.
    task automatic close_auto(input t_mode next_mode);
        trig_level  = 1'b0;
        shadow      = 1'b0;
        trig_mode   = next_mode;
        pulse_count = '0;
        led_level   = 1'b0;
    endtask

    // Compare pin levels with their active levels to form the key word.
    function automatic logic [KEY_W-1:0] decode_keys(input logic [DIRECT_W-1:0] pins,
                                                      input logic [MATRIX_W-1:0] cols);
        logic [KEY_W-1:0] word;
        word = '0;
        word[DIRECT_W-1:0] = ~(pins ^ lvl_direct);
        for (int i = 0; i < MATRIX_W; i++) begin
            word[i + DIRECT_W] = (cols[i] == lvl_matrix);
        end
        return word;
    endfunction

    // Advance the trigger machine by one item and form the status it reports.
    task automatic predict_status(input t_kind kind, input logic [DIRECT_W-1:0] pins,
                                  input logic [MATRIX_W-1:0] cols, input logic en,
                                  input logic [TIME_W-1:0] now, output t_status st);
        logic [KEY_W-1:0] word;
        logic             scan;
        logic             f1;
        word = '0;
        if (kind == KIND_CLEAR) begin
            // A clear restarts the pulse timing, but only in auto mode.
            if (trig_mode == MODE_AUTO) begin
                trig_level  = 1'b0;
                pulse_count = pulse_thr;
                auto_start  = now;
            end
        end else begin
            word = decode_keys(pins, cols);
            scan = |(word & SCAN_KEY_MASK);
            f1   = word[F1_BIT];
            if (!en) begin
                // Scanning disabled: auto drops back to manual, the key word stays whole.
                if (trig_mode == MODE_AUTO) begin
                    close_auto(MODE_MANUAL);
                end
            end else begin
                if (trig_mode == MODE_MANUAL) begin
                    // The trigger follows the scan keys; F1 starts arming.
                    if (!shadow && scan) begin
                        trig_level = 1'b1;
                        shadow     = 1'b1;
                    end else if (shadow && !scan) begin
                        trig_level = 1'b0;
                        shadow     = 1'b0;
                    end
                    if (f1 && scan) begin
                        shadow      = 1'b0;
                        trig_mode   = MODE_ARMING;
                        pulse_count = '0;
                        led_level   = 1'b1;
                        trig_level  = 1'b1;
                    end
                end else if (trig_mode == MODE_ARMING && !scan) begin
                    trig_mode  = MODE_AUTO;
                    auto_start = now;
                end else if (trig_mode == MODE_CLOSING && !scan) begin
                    trig_mode = MODE_MANUAL;
                end else if (trig_mode == MODE_AUTO) begin
                    // Pulse down-counter; the trigger toggles as it crosses the threshold.
                    if (pulse_count == '0) begin
                        pulse_count = pulse_reload;
                        shadow      = 1'b0;
                    end else begin
                        pulse_count = pulse_count - 1'b1;
                        if (!shadow && pulse_count >= pulse_thr) begin
                            trig_level = 1'b1;
                            shadow     = 1'b1;
                        end else if (shadow && pulse_count < pulse_thr) begin
                            trig_level = 1'b0;
                            shadow     = 1'b0;
                        end
                    end
                    // Timeout is measured modulo 2^32 so the stamp may wrap.
                    if ((now - auto_start) >= TIME_W'(auto_timeout) || (f1 && scan)) begin
                        close_auto(MODE_CLOSING);
                    end
                end
                word = word & ~SCAN_KEY_MASK;
            end
        end
        st.keys = word;
        st.trig = trig_level;
        st.led  = led_level;
        st.mode = trig_mode;
    endtask

    // Track configuration, compare results, predict from accepted polls.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lvl_direct   = RST_DIRECT_LEVELS;
            lvl_matrix   = RST_MATRIX_LEVEL;
            auto_timeout = RST_AUTO_TIMEOUT;
            pulse_reload = RST_PULSE_PERIOD;
            pulse_thr    = RST_PULSE_ON_THR;
            trig_mode    = MODE_MANUAL;
            shadow       = 1'b0;
            trig_level   = 1'b0;
            led_level    = 1'b0;
            pulse_count  = '0;
            auto_start   = '0;
            status_due.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_DIRECT_LEVELS: lvl_direct   = i_cfg_wdata[DIRECT_W-1:0];
                    CFG_MATRIX_LEVEL:  lvl_matrix   = i_cfg_wdata[0];
                    CFG_AUTO_TIMEOUT:  auto_timeout = i_cfg_wdata[TIMEOUT_W-1:0];
                    CFG_PULSE_PERIOD:  pulse_reload = i_cfg_wdata[COUNT_W-1:0];
                    CFG_PULSE_ON_THR:  pulse_thr    = i_cfg_wdata[COUNT_W-1:0];
                    default: ;
                endcase
            end

            if (m_axis_tvalid && m_axis_tready) begin
                got.keys = m_axis_tdata[OUT_KEY_LSB +: KEY_W];
                got.trig = m_axis_tdata[OUT_TRIG_BIT];
                got.led  = m_axis_tdata[OUT_LED_BIT];
                got.mode = t_mode'(m_axis_tdata[OUT_MODE_LSB +: MODE_W]);
                if (status_due.size() == 0) begin
                    report_mismatch($sformatf("result transfer with nothing expected, tdata %0h",
                                              m_axis_tdata));
                end else begin
                    want = status_due.pop_front();
                    if (got.keys !== want.keys)
                        report_mismatch($sformatf("key_status %06h, expected %06h",
                                                  got.keys, want.keys));
                    if (got.trig !== want.trig)
                        report_mismatch($sformatf("trigger_on %0b, expected %0b",
                                                  got.trig, want.trig));
                    if (got.led !== want.led)
                        report_mismatch($sformatf("led_red %0b, expected %0b",
                                                  got.led, want.led));
                    if (got.mode !== want.mode)
                        report_mismatch($sformatf("auto_mode %0d, expected %0d",
                                                  got.mode, want.mode));
                end
            end

            if (s_axis_tvalid && s_axis_tready) begin
                predict_status(t_kind'(s_axis_tuser),
                               s_axis_tdata[IN_DIRECT_LSB +: DIRECT_W],
                               s_axis_tdata[IN_MATRIX_LSB +: MATRIX_W],
                               s_axis_tdata[IN_ENABLE_BIT],
                               s_axis_tdata[IN_TIME_LSB +: TIME_W],
                               next_status);
                status_due.push_back(next_status);
            end
        end
        o_pending = status_due.size();
    end

endmodule

// File: sim/keypad_scan_trigger_controller_top_test.sv
// ============================================================================
// keypad_scan_trigger_controller_top_test: testbench top
// Drives directed and random key polls and clear events through the trigger
// mode sequences, under several register settings, with random idle cycles
// on both streams; the monitor predicts and checks every result.
// ============================================================================
`timescale 1ns / 100ps

module keypad_scan_trigger_controller_top_test;
    import kstc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // Bits up from 0: direct_pins[4], matrix_pins[20], scan_enable[1], now_time[32], zero pad.
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    // Bit 0: kind.
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // Bits up from 0: key_status[24], trigger_on[1], led_red[1], auto_mode[2], zero pad.
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    int                    fail_count;
    int                    pending;
    int                    cycle_count;
    int                    items_sent;
    logic                  steady_flow;
    logic [DIRECT_W-1:0]   pin_levels;
    logic [TIME_W-1:0]     now_stamp;

    keypad_scan_trigger_controller_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    kstc_trigger_monitor u_monitor (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Run length guard.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("keypad_scan_trigger_controller_top_test NOT OK");
            $finish;
        end
    end

    // Result side stalls at random, except during the steady stretch.
    always @(negedge i_clk) begin
        m_axis_tready <= steady_flow || ($urandom_range(99) >= 12);
    end

    // Present one item and hold it until its transfer.
    task automatic send_item(input t_kind kind, input logic [DIRECT_W-1:0] pins,
                             input logic [MATRIX_W-1:0] cols, input logic en,
                             input logic [TIME_W-1:0] now);
        logic [IN_DATA_W-1:0] word;
        word = '0;
        word[IN_DIRECT_LSB +: DIRECT_W] = pins;
        word[IN_MATRIX_LSB +: MATRIX_W] = cols;
        word[IN_ENABLE_BIT]             = en;
        word[IN_TIME_LSB +: TIME_W]     = now;
        while (!steady_flow && $urandom_range(99) < 12) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= word;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Send an item given as pressed keys; the time stamp advances or jumps.
    task automatic send_keys(input t_kind kind, input logic [DIRECT_W-1:0] pressed,
                             input logic en, input int dt_max);
        if ($urandom_range(99) == 0)
            now_stamp = $urandom;
        else
            now_stamp = now_stamp + TIME_W'($urandom_range(0, dt_max));
        send_item(kind, pin_levels ^ ~pressed, MATRIX_W'($urandom), en, now_stamp);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
    endtask

    // Wait until the block has drained, then write every register.
    task automatic load_settings(input logic [DIRECT_W-1:0] dl, input logic ml,
                                 input logic [TIMEOUT_W-1:0] timeout,
                                 input logic [COUNT_W-1:0] period,
                                 input logic [COUNT_W-1:0] thr);
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        cfg_write(CFG_DIRECT_LEVELS, CFG_DATA_W'(dl));
        cfg_write(CFG_MATRIX_LEVEL, CFG_DATA_W'(ml));
        cfg_write(CFG_AUTO_TIMEOUT, CFG_DATA_W'(timeout));
        cfg_write(CFG_PULSE_PERIOD, CFG_DATA_W'(period));
        cfg_write(CFG_PULSE_ON_THR, CFG_DATA_W'(thr));
        i_cfg_wr_en <= 1'b0;
        pin_levels = dl;
    endtask

    // Mostly full trigger sequences (manual, arm, auto run, stop, release),
    // with some bursts of unshaped items in between.
    task automatic run_phase(input int count, input int dt_max, input int auto_max);
        int         goal;
        int         roll;
        logic [2:0] pick;
        t_kind      kind;
        goal = items_sent + count;
        while (items_sent < goal) begin
            if ($urandom_range(99) < 70) begin
                repeat ($urandom_range(0, 3)) begin
                    pick = 3'($urandom);
                    send_keys(KIND_POLL, {1'b0, pick[1:0], pick[2]}, 1'b1, dt_max);
                end
                repeat ($urandom_range(1, 2)) begin
                    pick = 3'($urandom);
                    send_keys(KIND_POLL, {1'b1, pick[1:0], pick[2]}, 1'b1, dt_max);
                end
                repeat ($urandom_range(1, auto_max)) begin
                    pick = 3'($urandom);
                    roll = $urandom_range(99);
                    if (roll < 5)
                        send_keys(KIND_CLEAR, DIRECT_W'($urandom), 1'b1, dt_max);
                    else if (roll < 8)
                        send_keys(KIND_POLL, {3'b000, pick[2]}, 1'b0, dt_max);
                    else if (roll < 11)
                        send_keys(KIND_POLL, {1'b0, pick[1:0], pick[2]}, 1'b1, dt_max);
                    else
                        send_keys(KIND_POLL, {3'b000, pick[2]}, 1'b1, dt_max);
                end
                // Sometimes stop auto mode with F1 instead of waiting for the timeout.
                if ($urandom_range(1) == 1) begin
                    repeat ($urandom_range(1, 2)) begin
                        pick = 3'($urandom);
                        send_keys(KIND_POLL, {1'b1, pick[1:0], pick[2]}, 1'b1, dt_max);
                    end
                end
                repeat ($urandom_range(1, 3)) begin
                    pick = 3'($urandom);
                    send_keys(KIND_POLL, {3'b000, pick[2]}, 1'b1, dt_max);
                end
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    kind = ($urandom_range(99) < 20) ? KIND_CLEAR : KIND_POLL;
                    send_keys(kind, DIRECT_W'($urandom), 1'($urandom), dt_max);
                end
            end
        end
    endtask

    // Stimulus and verdict.
    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KIND_POLL;
        m_axis_tready = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_index   = CFG_DIRECT_LEVELS;
        i_cfg_wdata   = '0;
        cycle_count   = 0;
        items_sent    = 0;
        steady_flow   = 1'b0;
        pin_levels    = RST_DIRECT_LEVELS;
        now_stamp     = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part at reset settings: power is pressed at level 1, the
        // other direct keys and the matrix at level 0.
        send_item(KIND_POLL, 4'hE, 20'hFFFFF, 1'b1, 32'd0);         // nothing pressed
        send_item(KIND_POLL, 4'h1, 20'h00000, 1'b0, 32'd0);         // all pressed, disabled
        send_item(KIND_POLL, 4'hC, 20'hA5A5A, 1'b1, 32'd10);        // scan left: trigger on
        send_item(KIND_POLL, 4'hE, 20'h5A5A5, 1'b1, 32'd20);        // release: trigger off
        send_item(KIND_POLL, 4'h6, 20'h0F0F0, 1'b1, 32'd100);       // F1: arming
        send_item(KIND_POLL, 4'h6, 20'hF0F0F, 1'b0, 32'd150);       // arming kept when disabled
        send_item(KIND_POLL, 4'hE, 20'hFFFFF, 1'b1, 32'd200);       // release: auto
        send_item(KIND_POLL, 4'hE, 20'hFFFFF, 1'b1, 32'd210);
        send_item(KIND_POLL, 4'hE, 20'hFFFFF, 1'b1, 32'd220);
        send_item(KIND_POLL, 4'hE, 20'hFFFFF, 1'b1, 32'd230);
        send_item(KIND_CLEAR, 4'h0, 20'h00000, 1'b1, 32'd240);      // clear in auto
        send_item(KIND_POLL, 4'hE, 20'hFFFFF, 1'b1, 32'd250);
        send_item(KIND_POLL, 4'hE, 20'hFFFFF, 1'b0, 32'd260);       // disable ends auto
        send_item(KIND_POLL, 4'h6, 20'hFFFFF, 1'b1, 32'd1000);
        send_item(KIND_POLL, 4'hE, 20'hFFFFF, 1'b1, 32'd1000);
        send_item(KIND_POLL, 4'hE, 20'hFFFFF, 1'b1, 32'd13000);     // timeout: closing
        send_item(KIND_POLL, 4'hA, 20'hFFFFF, 1'b1, 32'd13010);     // held key keeps closing
        send_item(KIND_POLL, 4'hE, 20'hFFFFF, 1'b1, 32'd13020);     // back to manual
        send_item(KIND_POLL, 4'h6, 20'hFFFFF, 1'b1, 32'hFFFF_FF00);
        send_item(KIND_POLL, 4'hE, 20'hFFFFF, 1'b1, 32'hFFFF_FF00);
        send_item(KIND_POLL, 4'hE, 20'hFFFFF, 1'b1, 32'h0000_0010); // stamp wraps
        send_item(KIND_POLL, 4'h6, 20'hFFFFF, 1'b1, 32'h0000_0020); // F1 ends auto
        send_item(KIND_POLL, 4'hE, 20'hFFFFF, 1'b1, 32'h0000_0030);
        send_item(KIND_CLEAR, 4'hF, 20'hFFFFF, 1'b0, 32'hFFFF_FFFF); // clear in manual
        send_item(KIND_POLL, 4'h1, 20'h5A5A5, 1'b1, 32'h0000_0040);

        // Random part under several settings.
        run_phase(200, 400, 300);
        load_settings(4'hF, 1'b1, 16'd40, 9'd8, 9'd3);
        run_phase(200, 3, 40);
        load_settings(4'h0, 1'b0, 16'd0, 9'd0, 9'd0);
        run_phase(150, 5, 20);
        load_settings(4'hA, 1'b1, 16'hFFFF, 9'd511, 9'd511);
        run_phase(200, 3000, 60);
        load_settings(4'h5, 1'b0, 16'd1, 9'd1, 9'd0);
        run_phase(150, 2, 20);
        load_settings(4'h3, 1'b1, 16'd100, 9'd12, 9'd6);
        steady_flow = 1'b1;
        run_phase(250, 10, 80);
        steady_flow = 1'b0;
        load_settings(DIRECT_W'($urandom), 1'($urandom), TIMEOUT_W'($urandom_range(0, 300)),
                      COUNT_W'($urandom_range(0, 40)), COUNT_W'($urandom_range(0, 40)));
        run_phase(250, 8, 80);
        load_settings(4'hC, 1'b0, 16'd2000, 9'd511, 9'd0);
        run_phase(200, 50, 60);
        s_axis_tvalid <= 1'b0;

        // Drain and settle.
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("keypad_scan_trigger_controller_top_test OK");
        end else begin
            $display("keypad_scan_trigger_controller_top_test NOT OK");
        end
        $finish;
    end

endmodule
